/* rtl/core/rmq_pkg.sv */
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared constants for the rotation matrix to quaternion block: lane count
// and the place of each quaternion part in the lane arrays.
// ----------------------------------------------------------------------------
`default_nettype none

package rmq_pkg;

    // one lane per quaternion part
    localparam int NUM_LANES = 4;

    localparam int LANE_W = 0;
    localparam int LANE_X = 1;
    localparam int LANE_Y = 2;
    localparam int LANE_Z = 3;

endpackage : rmq_pkg

`default_nettype wire

/* rtl/core/rotation_matrix_to_quaternion.sv */
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// Rotation matrix (nine signed fixed-point elements) to unit quaternion by
// the copysign method, one pipelined digit-by-digit square root per part.
//
//   channel   ports                        handshake
//   -------   --------------------------   ----------------------------------
//   input     elem_00 .. elem_22           beat taken when start && !busy
//   result    quat_w, quat_x, quat_y,      beat shown for one cycle, done high
//             quat_z
//
// One beat is taken every cycle. The pipeline holds an input stage for the
// diagonal sums, the square root with one result bit per pipeline stage,
// and an output register.
// busy is never raised: the receiver cannot stall, so the pipeline never
// holds and no beat is lost or repeated.
// rst_n clears the valid bits only; data registers carry no reset.
// ----------------------------------------------------------------------------
`default_nettype none

module rotation_matrix_to_quaternion #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic signed [FRAC_BITS+1:0] elem_00,
    input  wire logic signed [FRAC_BITS+1:0] elem_01,
    input  wire logic signed [FRAC_BITS+1:0] elem_02,
    input  wire logic signed [FRAC_BITS+1:0] elem_10,
    input  wire logic signed [FRAC_BITS+1:0] elem_11,
    input  wire logic signed [FRAC_BITS+1:0] elem_12,
    input  wire logic signed [FRAC_BITS+1:0] elem_20,
    input  wire logic signed [FRAC_BITS+1:0] elem_21,
    input  wire logic signed [FRAC_BITS+1:0] elem_22,
    output logic                             done,
    output logic signed [FRAC_BITS+1:0]     quat_w,
    output logic signed [FRAC_BITS+1:0]     quat_x,
    output logic signed [FRAC_BITS+1:0]     quat_y,
    output logic signed [FRAC_BITS+1:0]     quat_z
);

    import rmq_pkg::*;

    // field width, sum width, clamped sum width
    localparam int W   = FRAC_BITS + 2;
    localparam int SW  = W + 2;
    localparam int CW  = SW - 1;
    // root bits (= sqrt stages), radicand width, remainder width
    localparam int N   = FRAC_BITS + 2;
    localparam int RW  = 2 * N;
    localparam int RMW = N + 2;

    // ------------------------------------------------------------------
    // pipeline registers
    // ------------------------------------------------------------------
    logic              vld_reg  [0:N];
    logic [NUM_LANES-1:0] neg_reg [0:N];
    logic [RW-1:0]     rad_reg  [0:N-1][NUM_LANES];
    logic [RMW-1:0]    rem_reg  [1:N-1][NUM_LANES];
    logic [N-1:0]      root_reg [1:N][NUM_LANES];

    logic              done_reg;
    logic [W-1:0]      quat_reg [NUM_LANES];

    logic              accept;

    // no back-pressure: a beat is taken in any cycle
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // ------------------------------------------------------------------
    // stage 0: diagonal sums, clamp, radicand and signs
    // ------------------------------------------------------------------
    logic signed [SW-1:0] e00_s, e11_s, e22_s, one_s;
    logic signed [SW-1:0] sum_s [NUM_LANES];
    logic [RW-1:0]        rad_next [NUM_LANES];
    logic [NUM_LANES-1:0] neg_next;

    assign e00_s = $signed({{2{elem_00[W-1]}}, elem_00});
    assign e11_s = $signed({{2{elem_11[W-1]}}, elem_11});
    assign e22_s = $signed({{2{elem_22[W-1]}}, elem_22});
    assign one_s = $signed({{(SW-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}});

    always_comb
    begin
        sum_s[LANE_W] = one_s + e00_s + e11_s + e22_s;
        sum_s[LANE_X] = one_s + e00_s - e11_s - e22_s;
        sum_s[LANE_Y] = one_s - e00_s + e11_s - e22_s;
        sum_s[LANE_Z] = one_s - e00_s - e11_s + e22_s;
        for (int l = 0; l < NUM_LANES; l++)
        begin
            // negative sum clamps to zero; radicand is sum << FRAC_BITS
            if (sum_s[l][SW-1])
                rad_next[l] = '0;
            else
                rad_next[l] = {1'b0, sum_s[l][CW-1:0], {FRAC_BITS{1'b0}}};
        end
        // sign of the off-diagonal differences, zero counts as positive
        neg_next         = '0;
        neg_next[LANE_X] = elem_21 < elem_12;
        neg_next[LANE_Y] = elem_02 < elem_20;
        neg_next[LANE_Z] = elem_10 < elem_01;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg[0] <= 1'b0;
        else
            vld_reg[0] <= accept;
    end

    always_ff @(posedge clk)
    begin
        neg_reg[0] <= neg_next;
        for (int l = 0; l < NUM_LANES; l++)
            rad_reg[0][l] <= rad_next[l];
    end

    // ------------------------------------------------------------------
    // stages 1..N: one root bit per stage and lane
    // ------------------------------------------------------------------
    for (genvar k = 1; k <= N; k++)
    begin : g_stage

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else
                vld_reg[k] <= vld_reg[k-1];
        end

        always_ff @(posedge clk)
        begin
            neg_reg[k] <= neg_reg[k-1];
        end

        for (genvar l = 0; l < NUM_LANES; l++)
        begin : g_lane
            logic [RMW-1:0] rem_in, rem_sh, trial;
            logic [N-1:0]   root_in, root_next;
            logic           ge;

            // first stage starts from a zero root and remainder
            if (k == 1)
            begin : g_first
                assign rem_in  = '0;
                assign root_in = '0;
            end
            else
            begin : g_mid
                assign rem_in  = rem_reg[k-1][l];
                assign root_in = root_reg[k-1][l];
            end

            // bring down the next digit pair and try root*4+1
            always_comb
            begin
                rem_sh    = {rem_in[RMW-3:0], rad_reg[k-1][l][RW-1:RW-2]};
                trial     = {root_in, 2'b01};
                ge        = rem_sh >= trial;
                root_next = {root_in[N-2:0], ge};
            end

            always_ff @(posedge clk)
            begin
                root_reg[k][l] <= root_next;
            end

            // remainder and radicand are not needed past the last bit
            if (k < N)
            begin : g_carry
                always_ff @(posedge clk)
                begin
                    rem_reg[k][l] <= ge ? (rem_sh - trial) : rem_sh;
                    rad_reg[k][l] <= {rad_reg[k-1][l][RW-3:0], 2'b00};
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // output: halve the root, apply sign, register
    // ------------------------------------------------------------------
    logic [W-1:0] mag [NUM_LANES];
    logic [W-1:0] quat_next [NUM_LANES];

    always_comb
    begin
        for (int l = 0; l < NUM_LANES; l++)
        begin
            mag[l]       = {1'b0, root_reg[N][l][N-1:1]};
            quat_next[l] = neg_reg[N][l] ? (W'(0) - mag[l]) : mag[l];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= vld_reg[N];
    end

    always_ff @(posedge clk)
    begin
        for (int l = 0; l < NUM_LANES; l++)
            quat_reg[l] <= quat_next[l];
    end

    assign done   = done_reg;
    assign quat_w = $signed(quat_reg[LANE_W]);
    assign quat_x = $signed(quat_reg[LANE_X]);
    assign quat_y = $signed(quat_reg[LANE_Y]);
    assign quat_z = $signed(quat_reg[LANE_Z]);

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    // every accepted beat leaves after the fixed latency
    a_latency_fwd : assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##(N+2) done)
        else $error("accepted beat did not produce a result");

    // no result without a beat accepted at the matching edge
    a_latency_bwd : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, N+2))
        else $error("result without a matching accepted beat");

    // scalar part is never negative
    a_w_positive : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !quat_w[W-1])
        else $error("negative scalar part");

endmodule : rotation_matrix_to_quaternion

`default_nettype wire

/* dv/rotation_matrix_to_quaternion_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_tb
// Self-checking bench for the matrix to quaternion block. Matrix beats go in
// with random gaps. A scoreboard predicts each quaternion from the diagonal
// sums, the floor square root and the sign of the off-diagonal differences.
// It then checks every result beat, field by field, in order.
// ----------------------------------------------------------------------------

module rotation_matrix_to_quaternion_tb;

    localparam int FRAC_BITS      = 16;
    localparam int W              = FRAC_BITS + 2;
    localparam int LATENCY        = FRAC_BITS + 4;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int NUM_RANDOM     = 550;

    localparam longint ONE_FX = longint'(1) << FRAC_BITS;
    localparam longint MAX_FX = (longint'(1) << (W - 1)) - 1;
    localparam longint MIN_FX = -(longint'(1) << (W - 1));

    typedef logic signed [W-1:0] fix_t;
    typedef longint unsigned     u64_t;

    typedef struct packed {
        fix_t e00, e01, e02;
        fix_t e10, e11, e12;
        fix_t e20, e21, e22;
    } matrix_t;

    typedef struct packed {
        fix_t w, x, y, z;
    } quat_t;

    // ------------------------------------------------------------------------
    // Scoreboard: predicts a quaternion per matrix beat, checks result beats
    // ------------------------------------------------------------------------
    class quat_scoreboard;
        quat_t expected_q[$];
        int    errors;

        function new();
            errors = 0;
        endfunction

        // floor(sqrt(v)), built one result bit at a time from the top
        static function u64_t root_floor(u64_t v);
            u64_t r;
            u64_t trial;
            r = 0;
            for (int b = 31; b >= 0; b--) begin
                trial = r | (u64_t'(1) << b);
                if (trial * trial <= v)
                    r = trial;
            end
            return r;
        endfunction

        // clamped sum -> halved fixed-point root
        static function longint half_mag(longint sum);
            if (sum < 0)
                return 0;
            return longint'(root_floor(u64_t'(sum) << FRAC_BITS) >> 1);
        endfunction

        // a zero difference counts as positive
        static function fix_t signed_part(longint mag, longint diff);
            return fix_t'((diff < 0) ? -mag : mag);
        endfunction

        static function longint wide(fix_t v);
            return v;
        endfunction

        static function quat_t quaternion_of(matrix_t m);
            longint a00, a01, a02, a10, a11, a12, a20, a21, a22;
            quat_t  q;
            a00 = wide(m.e00); a01 = wide(m.e01); a02 = wide(m.e02);
            a10 = wide(m.e10); a11 = wide(m.e11); a12 = wide(m.e12);
            a20 = wide(m.e20); a21 = wide(m.e21); a22 = wide(m.e22);
            q.w = fix_t'(half_mag(ONE_FX + a00 + a11 + a22));
            q.x = signed_part(half_mag(ONE_FX + a00 - a11 - a22), a21 - a12);
            q.y = signed_part(half_mag(ONE_FX - a00 + a11 - a22), a02 - a20);
            q.z = signed_part(half_mag(ONE_FX - a00 - a11 + a22), a10 - a01);
            return q;
        endfunction

        function void note_matrix(matrix_t m);
            expected_q.push_back(quaternion_of(m));
        endfunction

        function void check_quat(quat_t got);
            quat_t exp_q;
            if (expected_q.size() == 0) begin
                $error("result beat with no matrix waiting: w=%0d x=%0d y=%0d z=%0d",
                       got.w, got.x, got.y, got.z);
                errors++;
                return;
            end
            exp_q = expected_q.pop_front();
            if (got.w !== exp_q.w) begin
                $error("quat_w: expected %0d, got %0d", exp_q.w, got.w);
                errors++;
            end
            if (got.x !== exp_q.x) begin
                $error("quat_x: expected %0d, got %0d", exp_q.x, got.x);
                errors++;
            end
            if (got.y !== exp_q.y) begin
                $error("quat_y: expected %0d, got %0d", exp_q.y, got.y);
                errors++;
            end
            if (got.z !== exp_q.z) begin
                $error("quat_z: expected %0d, got %0d", exp_q.z, got.z);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals and block under test
    // ------------------------------------------------------------------------
    logic clk;
    logic rst_n   = 1'b0;
    logic start   = 1'b0;
    fix_t elem_00 = '0;
    fix_t elem_01 = '0;
    fix_t elem_02 = '0;
    fix_t elem_10 = '0;
    fix_t elem_11 = '0;
    fix_t elem_12 = '0;
    fix_t elem_20 = '0;
    fix_t elem_21 = '0;
    fix_t elem_22 = '0;
    logic busy;
    logic done;
    fix_t quat_w;
    fix_t quat_x;
    fix_t quat_y;
    fix_t quat_z;

    quat_scoreboard sb;
    int             idle_cycles = 0;

    rotation_matrix_to_quaternion #(
        .FRAC_BITS (FRAC_BITS)
    ) u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .elem_00 (elem_00),
        .elem_01 (elem_01),
        .elem_02 (elem_02),
        .elem_10 (elem_10),
        .elem_11 (elem_11),
        .elem_12 (elem_12),
        .elem_20 (elem_20),
        .elem_21 (elem_21),
        .elem_22 (elem_22),
        .done    (done),
        .quat_w  (quat_w),
        .quat_x  (quat_x),
        .quat_y  (quat_y),
        .quat_z  (quat_z)
    );

    // 10 ns clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Monitor: both channels sampled on the rising edge, plus the watchdog
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                sb.check_quat(quat_t'({quat_w, quat_x, quat_y, quat_z}));
            if (start && !busy)
                sb.note_matrix(matrix_t'({elem_00, elem_01, elem_02,
                                          elem_10, elem_11, elem_12,
                                          elem_20, elem_21, elem_22}));
        end
        // stall detection: nothing taken on either side for too long
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic matrix_t mk(longint a00, longint a01, longint a02,
                                   longint a10, longint a11, longint a12,
                                   longint a20, longint a21, longint a22);
        matrix_t m;
        m = '{fix_t'(a00), fix_t'(a01), fix_t'(a02),
              fix_t'(a10), fix_t'(a11), fix_t'(a12),
              fix_t'(a20), fix_t'(a21), fix_t'(a22)};
        return m;
    endfunction

    // real element -> fixed point with a little noise, clamped to the field
    function automatic longint to_fix(real r);
        longint v;
        v = longint'($rtoi(r * real'(ONE_FX))) + longint'($urandom_range(0, 8)) - 4;
        if (v > MAX_FX)
            v = MAX_FX;
        if (v < MIN_FX)
            v = MIN_FX;
        return v;
    endfunction

    // near-rotation matrix built from a random quaternion
    function automatic matrix_t rand_rotation();
        real qw, qx, qy, qz, n;
        qw = real'($urandom_range(0, 2000)) / 1000.0 - 1.0;
        qx = real'($urandom_range(0, 2000)) / 1000.0 - 1.0;
        qy = real'($urandom_range(0, 2000)) / 1000.0 - 1.0;
        qz = real'($urandom_range(0, 2000)) / 1000.0 - 1.0;
        n  = $sqrt(qw * qw + qx * qx + qy * qy + qz * qz);
        if (n < 0.001)
        begin
            qw = 1.0;
            n  = 1.0;
        end
        qw = qw / n; qx = qx / n; qy = qy / n; qz = qz / n;
        return mk(to_fix(1.0 - 2.0 * (qy * qy + qz * qz)),
                  to_fix(2.0 * (qx * qy - qw * qz)),
                  to_fix(2.0 * (qx * qz + qw * qy)),
                  to_fix(2.0 * (qx * qy + qw * qz)),
                  to_fix(1.0 - 2.0 * (qx * qx + qz * qz)),
                  to_fix(2.0 * (qy * qz - qw * qx)),
                  to_fix(2.0 * (qx * qz - qw * qy)),
                  to_fix(2.0 * (qy * qz + qw * qx)),
                  to_fix(1.0 - 2.0 * (qx * qx + qy * qy)));
    endfunction

    // field drawn from the corner values, or fully random
    function automatic longint corner_field();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return ONE_FX;
            2: return -ONE_FX;
            3: return MAX_FX;
            4: return MIN_FX;
            default: return longint'(fix_t'($urandom));
        endcase
    endfunction

    function automatic matrix_t rand_matrix();
        int k;
        k = $urandom_range(0, 9);
        if (k < 6)
            return rand_rotation();
        if (k < 8)
            return mk(longint'(fix_t'($urandom)), longint'(fix_t'($urandom)),
                      longint'(fix_t'($urandom)), longint'(fix_t'($urandom)),
                      longint'(fix_t'($urandom)), longint'(fix_t'($urandom)),
                      longint'(fix_t'($urandom)), longint'(fix_t'($urandom)),
                      longint'(fix_t'($urandom)));
        return mk(corner_field(), corner_field(), corner_field(),
                  corner_field(), corner_field(), corner_field(),
                  corner_field(), corner_field(), corner_field());
    endfunction

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // one matrix beat, after an optional gap; returns once it is taken
    task automatic send_matrix(input matrix_t m, input int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        elem_00 <= m.e00;
        elem_01 <= m.e01;
        elem_02 <= m.e02;
        elem_10 <= m.e10;
        elem_11 <= m.e11;
        elem_12 <= m.e12;
        elem_20 <= m.e20;
        elem_21 <= m.e21;
        elem_22 <= m.e22;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // hold off until every predicted quaternion has come back
    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        sb = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed: rotations about each axis, extremes, clamping, sign rules
        send_matrix(mk(ONE_FX, 0, 0, 0, ONE_FX, 0, 0, 0, ONE_FX), pick_gap());
        send_matrix(mk(ONE_FX, 0, 0, 0, -ONE_FX, 0, 0, 0, -ONE_FX), pick_gap());
        send_matrix(mk(-ONE_FX, 0, 0, 0, ONE_FX, 0, 0, 0, -ONE_FX), pick_gap());
        send_matrix(mk(-ONE_FX, 0, 0, 0, -ONE_FX, 0, 0, 0, ONE_FX), pick_gap());
        send_matrix(mk(ONE_FX, 0, 0, 0, 0, -ONE_FX, 0, ONE_FX, 0), pick_gap());
        send_matrix(mk(ONE_FX, 0, 0, 0, 0, ONE_FX, 0, -ONE_FX, 0), pick_gap());
        send_matrix(mk(0, 0, ONE_FX, 0, ONE_FX, 0, -ONE_FX, 0, 0), pick_gap());
        send_matrix(mk(0, 0, -ONE_FX, 0, ONE_FX, 0, ONE_FX, 0, 0), pick_gap());
        send_matrix(mk(0, -ONE_FX, 0, ONE_FX, 0, 0, 0, 0, ONE_FX), pick_gap());
        send_matrix(mk(0, ONE_FX, 0, -ONE_FX, 0, 0, 0, 0, ONE_FX), pick_gap());
        send_matrix(mk(MAX_FX, MAX_FX, MAX_FX, MAX_FX, MAX_FX, MAX_FX,
                       MAX_FX, MAX_FX, MAX_FX), pick_gap());
        send_matrix(mk(MIN_FX, MIN_FX, MIN_FX, MIN_FX, MIN_FX, MIN_FX,
                       MIN_FX, MIN_FX, MIN_FX), pick_gap());
        send_matrix(mk(MIN_FX, MAX_FX, MAX_FX, MAX_FX, MIN_FX, MAX_FX,
                       MAX_FX, MAX_FX, MIN_FX), pick_gap());
        send_matrix(mk(0, 0, 0, 0, 0, 0, 0, 0, 0), pick_gap());
        // zero magnitude with a negative difference on every vector part
        send_matrix(mk(ONE_FX, ONE_FX, 0, 0, ONE_FX, ONE_FX, ONE_FX, 0, ONE_FX),
                    pick_gap());
        send_matrix(mk('h2AAAA, 'h2AAAA, 'h2AAAA, 'h2AAAA, 'h2AAAA, 'h2AAAA,
                       'h2AAAA, 'h2AAAA, 'h2AAAA), pick_gap());
        send_matrix(mk('h15555, 'h15555, 'h15555, 'h15555, 'h15555, 'h15555,
                       'h15555, 'h15555, 'h15555), pick_gap());
        send_matrix(mk(MAX_FX, MAX_FX, MIN_FX, MIN_FX, MAX_FX, MAX_FX,
                       MAX_FX, MIN_FX, MAX_FX), pick_gap());
        send_matrix(mk(MAX_FX, 0, 0, 0, MIN_FX, 0, 0, 0, MAX_FX), pick_gap());
        send_matrix(mk(-ONE_FX, 0, 0, 0, -ONE_FX, 0, 0, 0, -ONE_FX), pick_gap());
        drain_results();

        // random: bursts with no gaps every third block of forty beats
        for (int i = 0; i < NUM_RANDOM; i++)
        begin
            if (i == NUM_RANDOM / 2)
                drain_results();
            send_matrix(rand_matrix(), ((i / 40) % 3 == 0) ? 0 : pick_gap());
        end
        drain_results();
        repeat (LATENCY + 4) @(posedge clk);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule : rotation_matrix_to_quaternion_tb
